### rtl/dgbp_pkg.sv
// Package for the dithered gray bit-plane packer.
// Holds the transaction structs, register indexes, defaults and the quantiser.
// No dependencies.
`default_nettype none

package dgbp_pkg;

    localparam int PANEL_WIDTH_DEF = 800;
    localparam int PANEL_ROWS_DEF  = 480;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_DITHER_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MONO_MODE     = 2'd1;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 2;

    typedef struct packed {
        logic        kind;
        logic [7:0]  luma;
        logic [9:0]  origin_x;
        logic [8:0]  origin_y;
        logic [9:0]  col_offset;
        logic [8:0]  row_offset;
        logic [15:0] read_address;
    } item_t;

    typedef struct packed {
        logic [1:0]  gray_level;
        logic [15:0] byte_address;
        logic [7:0]  plane_low_byte;
        logic [7:0]  plane_high_byte;
        logic        out_of_range;
    } result_t;

    // Classified command from front to back; the plane address travels beside it.
    typedef struct packed {
        logic        is_read;
        logic        oor;
        logic [1:0]  level;
        logic [2:0]  bit_sel;
        logic [15:0] byte_address;
    } cmd_t;

    function automatic logic [3:0] bayer(input logic [1:0] yl, input logic [1:0] xl);
        logic [3:0] b;
        case ({yl, xl})
            4'h0: b = 4'd0;
            4'h1: b = 4'd8;
            4'h2: b = 4'd2;
            4'h3: b = 4'd10;
            4'h4: b = 4'd12;
            4'h5: b = 4'd4;
            4'h6: b = 4'd14;
            4'h7: b = 4'd6;
            4'h8: b = 4'd3;
            4'h9: b = 4'd11;
            4'hA: b = 4'd1;
            4'hB: b = 4'd9;
            4'hC: b = 4'd15;
            4'hD: b = 4'd7;
            4'hE: b = 4'd13;
            4'hF: b = 4'd5;
            default: b = 4'd0;
        endcase
        return b;
    endfunction

    function automatic logic [1:0] quantise(
        input logic [7:0] luma,
        input logic [1:0] xl,
        input logic [1:0] yl,
        input logic       mono,
        input logic       dith
    );
        logic [3:0]  b;
        logic [9:0]  s;
        logic [1:0]  base;
        logic [9:0]  frac;
        logic [11:0] thr;
        logic [2:0]  lvl;
        logic [1:0]  q;
        b = bayer(yl, xl);
        s = {1'b0, luma, 1'b0} + {2'b00, luma};
        if (s >= 10'd765)
            base = 2'd3;
        else if (s >= 10'd510)
            base = 2'd2;
        else if (s >= 10'd255)
            base = 2'd1;
        else
            base = 2'd0;
        case (base)
            2'd0:    frac = s;
            2'd1:    frac = s - 10'd255;
            2'd2:    frac = s - 10'd510;
            default: frac = s - 10'd765;
        endcase
        thr = (12'(b) * 12'd255) >> 4;
        lvl = {1'b0, base} + 3'({2'b00, frac} > thr);
        if (mono) begin
            if (dith)
                q = (luma > {b, 4'h8}) ? 2'd3 : 2'd0;
            else
                q = luma[7] ? 2'd3 : 2'd0;
        end
        else if (!dith)
            q = luma[7:6];
        else
            q = (lvl > 3'd3) ? 2'd3 : lvl[1:0];
        return q;
    endfunction

endpackage

`default_nettype wire

### rtl/dithered_gray_bitplane_packer.sv
// Top level of the dithered gray bit-plane packer.
// Depends on dgbp_pkg, dgbp_front, dgbp_fifo and dgbp_back.
//
// After reset the two bit planes are cleared one byte of each per cycle, over all
// PANEL_ROWS * ceil(PANEL_WIDTH / 8) byte addresses (48000 at the defaults); full
// stays high for that time, config writes are taken throughout. Afterwards the block
// sustains one transaction per cycle while each result is popped as it arrives; an
// item goes through input register, command queue, memory read, then modify/write
// into the result queue before its result shows on the ports. The rate is set by the
// single read-modify-write per pixel on the one-read, one-write plane memory, with the
// last written byte forwarded to a following access of the same address.
`default_nettype none

module dithered_gray_bitplane_packer #(
    parameter int PANEL_WIDTH = dgbp_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_ROWS  = dgbp_pkg::PANEL_ROWS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire dgbp_pkg::item_t                  item,
    input  wire logic                             push,
    output logic                                  full,
    output dgbp_pkg::result_t                     result,
    output logic                                  empty,
    input  wire logic                             pop,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [dgbp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic                             cfg_data
);

    localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
    localparam int PLANE_BYTES = ROW_BYTES * PANEL_ROWS;
    localparam int ADDR_W      = (PLANE_BYTES > 1) ? $clog2(PLANE_BYTES) : 1;
    localparam int CMD_W       = $bits(dgbp_pkg::cmd_t) + ADDR_W;
    localparam int RES_W       = $bits(dgbp_pkg::result_t);

    logic              clearing;
    logic              cmd_push, cmd_full, cmd_pop, cmd_empty;
    logic [CMD_W-1:0]  cmd_in, cmd_out;
    logic              res_push, res_full;
    dgbp_pkg::result_t res_in;
    logic [RES_W-1:0]  res_out;

    dgbp_front #(
        .PANEL_WIDTH (PANEL_WIDTH),
        .PANEL_ROWS  (PANEL_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .push      (push),
        .full      (full),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .clearing  (clearing),
        .cmd_push  (cmd_push),
        .cmd_data  (cmd_in),
        .cmd_full  (cmd_full)
    );

    dgbp_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (dgbp_pkg::MID_DEPTH)
    ) u_cmd_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .empty     (cmd_empty)
    );

    dgbp_back #(
        .PANEL_WIDTH (PANEL_WIDTH),
        .PANEL_ROWS  (PANEL_ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_data  (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res_data  (res_in),
        .res_full  (res_full),
        .clearing  (clearing)
    );

    dgbp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (dgbp_pkg::OUT_DEPTH)
    ) u_res_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_in),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (res_out),
        .empty     (empty)
    );

    assign result = dgbp_pkg::result_t'(res_out);

endmodule

`default_nettype wire

### rtl/dgbp_fifo.sv
// Small synchronous queue of flat words, DEPTH a power of two.
// No dependencies.
`default_nettype none

module dgbp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] slot_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_mem[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

### rtl/dgbp_front.sv
// Front end: config registers, input register, coordinate/address math and quantiser.
// Depends on dgbp_pkg.
`default_nettype none

module dgbp_front #(
    parameter int PANEL_WIDTH = dgbp_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_ROWS  = dgbp_pkg::PANEL_ROWS_DEF,
    localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8,
    localparam int PLANE_BYTES = ROW_BYTES * PANEL_ROWS,
    localparam int ADDR_W      = (PLANE_BYTES > 1) ? $clog2(PLANE_BYTES) : 1,
    localparam int CMD_W       = $bits(dgbp_pkg::cmd_t) + ADDR_W
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire dgbp_pkg::item_t                item,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [dgbp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic                           cfg_data,
    input  wire logic                           clearing,
    output logic                                cmd_push,
    output logic [CMD_W-1:0]                    cmd_data,
    input  wire logic                           cmd_full
);

    logic        dither_enable_reg;
    logic        mono_mode_reg;
    logic        f1_valid_reg, f1_valid_next;
    logic        f1_kind_reg;
    logic [7:0]  f1_luma_reg;
    logic [10:0] f1_x_reg;
    logic [9:0]  f1_y_reg;
    logic [15:0] f1_raddr_reg;
    logic        accept;

    logic              x_in, y_in, rd_in;
    logic [ADDR_W-1:0] row_base, wr_addr, mem_addr;
    dgbp_pkg::cmd_t    cmd;

    assign cfg_ready = 1'b1;
    assign full      = clearing || (f1_valid_reg && cmd_full);
    assign accept    = push && !full;
    assign cmd_push  = f1_valid_reg && !cmd_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dither_enable_reg <= 1'b0;
            mono_mode_reg     <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                dgbp_pkg::REG_DITHER_ENABLE: dither_enable_reg <= cfg_data;
                dgbp_pkg::REG_MONO_MODE:     mono_mode_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        f1_valid_next = f1_valid_reg;
        if (accept)
            f1_valid_next = 1'b1;
        else if (cmd_push)
            f1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1_valid_reg <= 1'b0;
        else
            f1_valid_reg <= f1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_kind_reg  <= item.kind;
            f1_luma_reg  <= item.luma;
            f1_x_reg     <= {1'b0, item.origin_x} + {1'b0, item.col_offset};
            f1_y_reg     <= {1'b0, item.origin_y} + {1'b0, item.row_offset};
            f1_raddr_reg <= item.read_address;
        end
    end

    always_comb
    begin
        x_in     = ({1'b0, f1_x_reg} < 12'(PANEL_WIDTH));
        y_in     = ({2'b00, f1_y_reg} < 12'(PANEL_ROWS));
        rd_in    = ({16'd0, f1_raddr_reg} < 32'(PLANE_BYTES));
        row_base = ADDR_W'(f1_y_reg) * ADDR_W'(ROW_BYTES);
        wr_addr  = row_base + ADDR_W'(f1_x_reg[10:3]);

        if (f1_kind_reg == dgbp_pkg::KIND_READ)
        begin
            cmd.is_read      = 1'b1;
            cmd.oor          = !rd_in;
            cmd.level        = 2'd0;
            cmd.bit_sel      = 3'd0;
            cmd.byte_address = f1_raddr_reg;
            mem_addr         = rd_in ? ADDR_W'(f1_raddr_reg) : '0;
        end
        else
        begin
            cmd.is_read      = 1'b0;
            cmd.oor          = !(x_in && y_in);
            cmd.level        = dgbp_pkg::quantise(f1_luma_reg, f1_x_reg[1:0], f1_y_reg[1:0],
                                                  mono_mode_reg, dither_enable_reg);
            cmd.bit_sel      = f1_x_reg[2:0];
            cmd.byte_address = cmd.oor ? 16'd0 : 16'(wr_addr);
            mem_addr         = cmd.oor ? '0 : wr_addr;
        end
        cmd_data = {cmd, mem_addr};
    end

endmodule

`default_nettype wire

### rtl/dgbp_back.sv
// Back end: plane memory with post-reset clear, read-modify-write with last-write forwarding.
// Depends on dgbp_pkg.
`default_nettype none

module dgbp_back #(
    parameter int PANEL_WIDTH = dgbp_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_ROWS  = dgbp_pkg::PANEL_ROWS_DEF,
    localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8,
    localparam int PLANE_BYTES = ROW_BYTES * PANEL_ROWS,
    localparam int ADDR_W      = (PLANE_BYTES > 1) ? $clog2(PLANE_BYTES) : 1,
    localparam int CMD_W       = $bits(dgbp_pkg::cmd_t) + ADDR_W
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CMD_W-1:0] cmd_data,
    input  wire logic             cmd_empty,
    output logic                  cmd_pop,
    output logic                  res_push,
    output dgbp_pkg::result_t     res_data,
    input  wire logic             res_full,
    output logic                  clearing
);

    // {high plane byte, low plane byte}
    logic [15:0] plane_mem [PLANE_BYTES];

    logic              clearing_reg, clearing_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              s2_valid_reg, s2_valid_next;
    dgbp_pkg::cmd_t    s2_cmd_reg;
    logic [ADDR_W-1:0] s2_addr_reg;
    logic [15:0]       rdata_reg;
    logic              lw_valid_reg;
    logic [ADDR_W-1:0] lw_addr_reg;
    logic [15:0]       lw_data_reg;

    dgbp_pkg::cmd_t    head_cmd;
    logic [ADDR_W-1:0] head_addr;
    logic              s2_adv, s2_write, wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data, cur, upd;
    logic [7:0]        mask;

    assign head_cmd  = dgbp_pkg::cmd_t'(cmd_data[CMD_W-1:ADDR_W]);
    assign head_addr = cmd_data[ADDR_W-1:0];
    assign clearing  = clearing_reg;

    assign s2_adv   = !s2_valid_reg || !res_full;
    assign cmd_pop  = !clearing_reg && s2_adv && !cmd_empty;
    assign res_push = s2_valid_reg && !res_full;
    assign s2_write = res_push && !s2_cmd_reg.is_read && !s2_cmd_reg.oor;

    always_comb
    begin
        cur  = (lw_valid_reg && lw_addr_reg == s2_addr_reg) ? lw_data_reg : rdata_reg;
        mask = 8'h80 >> s2_cmd_reg.bit_sel;
        upd[7:0]  = s2_cmd_reg.level[0] ? (cur[7:0] | mask) : (cur[7:0] & ~mask);
        upd[15:8] = s2_cmd_reg.level[1] ? (cur[15:8] | mask) : (cur[15:8] & ~mask);

        wr_en   = clearing_reg || s2_write;
        wr_addr = clearing_reg ? clr_addr_reg : s2_addr_reg;
        wr_data = clearing_reg ? 16'd0 : upd;

        res_data.gray_level   = s2_cmd_reg.level;
        res_data.byte_address = s2_cmd_reg.byte_address;
        res_data.out_of_range = s2_cmd_reg.oor;
        if (s2_cmd_reg.oor)
        begin
            res_data.plane_low_byte  = 8'd0;
            res_data.plane_high_byte = 8'd0;
        end
        else if (s2_cmd_reg.is_read)
        begin
            res_data.plane_low_byte  = cur[7:0];
            res_data.plane_high_byte = cur[15:8];
        end
        else
        begin
            res_data.plane_low_byte  = upd[7:0];
            res_data.plane_high_byte = upd[15:8];
        end
    end

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            if (clr_addr_reg == ADDR_W'(PLANE_BYTES - 1))
                clearing_next = 1'b0;
            else
                clr_addr_next = clr_addr_reg + 1'b1;
        end
        s2_valid_next = s2_adv ? cmd_pop : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            s2_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
            s2_valid_reg <= s2_valid_next;
            if (s2_write)
                lw_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            s2_cmd_reg  <= head_cmd;
            s2_addr_reg <= head_addr;
        end
        if (s2_write)
        begin
            lw_addr_reg <= s2_addr_reg;
            lw_data_reg <= upd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            plane_mem[wr_addr] <= wr_data;
        if (cmd_pop)
            rdata_reg <= plane_mem[head_addr];
    end

endmodule

`default_nettype wire
